// ===== hdl/tcw_pkg.sv =====
// Shared constants, codes, types and the ring address function for the text console character writer.
// Depends on nothing; imported by the top level.
package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;

  // Field widths
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = 11;
  localparam int CELL_W = 16;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int OP_W   = 2;

  localparam int TAB_WIDTH = 8;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h0F;
  localparam logic [CELL_W-1:0] BLANK_RESET = {ATTR_RESET, CH_SPACE};

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_READ,
    S_SCROLL,
    S_FILL,
    S_DONE
  } state_t;

  // Logical linear index plus ring base, folded back into the screen store.
  function automatic logic [ADDR_W-1:0] phys_addr(input logic [ADDR_W-1:0] lin,
                                                  input logic [ADDR_W-1:0] base);
    logic [ADDR_W:0] sum;
    sum = {1'b0, lin} + {1'b0, base};
    if (sum >= (ADDR_W+1)'(CELLS)) begin
      sum = sum - (ADDR_W+1)'(CELLS);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

// ===== hdl/tcw_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/text_console_character_writer.sv =====
// Text console character writer: 80x25 cell screen store, cursor and control.
// Depends on tcw_pkg and tcw_ram.
//
// Usage
//   Input channel (in_valid/in_stall) carries one command beat: opcode,
//   char_code, cell_address. Output channel (out_valid/out_stall) returns
//   one result beat per command: cursor column, row, linear offset and,
//   for a read, the cell. Configuration channel (cfg_valid/cfg_ready) writes
//   the attribute byte; it is always ready.
// States from input beat to output beat:
//   put without scroll, control codes, unused opcode, read past the end:
//     S_EXEC, S_DONE
//   read inside the screen: S_EXEC, S_READ (for the registered read), S_DONE
//   put that scrolls: S_EXEC, S_SCROLL (one screen row of blank writes), S_DONE
//   clear: S_EXEC, S_FILL (every cell written once), S_DONE
//   One command is worked on at a time; the next is taken only in S_IDLE.
//   Rows form a ring, so a scroll moves a base pointer, not cells.
// Reset: rst clears the cursor, sets the attribute to ATTR_RESET and starts a
//   pass that writes blank cells into the whole store; in_stall stays high.
// A stalled result is held in the output register; the next command may
//   still be taken and is finished up to the point of handing over.
module text_console_character_writer (
  input  logic                         clk,
  input  logic                         rst,
  // command channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tcw_pkg::OP_W-1:0]     opcode,
  input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
  input  logic [tcw_pkg::ADDR_W-1:0]   cell_address,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tcw_pkg::COL_W-1:0]    cursor_column,
  output logic [tcw_pkg::ROW_W-1:0]    cursor_row,
  output logic [tcw_pkg::ADDR_W-1:0]   cursor_offset,
  output logic [tcw_pkg::CELL_W-1:0]   cell_data,
  // configuration channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tcw_pkg::ATTR_W-1:0]   cfg_data
);

  import tcw_pkg::*;

  state_t state, state_next;

  // Command held for the duration of the work
  opcode_t           op_q;
  logic [CHAR_W-1:0] code_q;
  logic [ADDR_W-1:0] addr_q;

  // Architectural state
  logic [ATTR_W-1:0] attribute;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [ADDR_W-1:0] cur_off;
  logic [ADDR_W-1:0] top_base;   // physical start of logical row 0
  logic [ADDR_W-1:0] sweep_cnt;
  logic [CELL_W-1:0] res_data;

  // RAM ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  // Decode results of the put command
  logic [COL_W:0]    col_step;
  logic [COL_W:0]    col_tab;
  logic [ROW_W:0]    row_step;
  logic [COL_W-1:0]  col_fin;
  logic [ROW_W-1:0]  row_fin;
  logic [ADDR_W-1:0] off_fin;
  logic              is_print;
  logic              need_scroll;
  logic              read_ok;
  logic              out_load;
  logic              sweep_last_row;
  logic              sweep_last_cell;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_load  = (state == S_DONE) && (!out_valid || !out_stall);

  assign sweep_last_row  = (sweep_cnt == ADDR_W'(COLUMNS - 1));
  assign sweep_last_cell = (sweep_cnt == ADDR_W'(CELLS - 1));

  // Cursor movement for a put
  always_comb begin
    col_step = {1'b0, cur_col};
    row_step = {1'b0, cur_row};
    col_tab  = {1'b0, cur_col} + (COL_W+1)'(TAB_WIDTH);
    is_print = (code_q >= CH_SPACE);
    priority if (code_q == CH_BS) begin
      if (cur_col != '0) begin
        col_step = {1'b0, cur_col} - (COL_W+1)'(1);
      end
    end else if (code_q == CH_TAB) begin
      col_step = {col_tab[COL_W:3], 3'b000};
    end else if (code_q == CH_CR) begin
      col_step = '0;
    end else if (code_q == CH_LF) begin
      col_step = '0;
      row_step = {1'b0, cur_row} + (ROW_W+1)'(1);
    end else if (is_print) begin
      col_step = {1'b0, cur_col} + (COL_W+1)'(1);
    end else begin
      // other control codes leave the cursor where it is
      col_step = {1'b0, cur_col};
    end
    // wrap at the right edge
    if (col_step >= (COL_W+1)'(COLUMNS)) begin
      col_step = '0;
      row_step = row_step + (ROW_W+1)'(1);
    end
    // past the bottom: scroll and stay on the last row
    need_scroll = (row_step >= (ROW_W+1)'(ROWS));
    col_fin = col_step[COL_W-1:0];
    row_fin = need_scroll ? ROW_W'(ROWS - 1) : row_step[ROW_W-1:0];
    off_fin = ADDR_W'(row_fin) * ADDR_W'(COLUMNS) + ADDR_W'(col_fin);
  end

  assign read_ok = (addr_q < ADDR_W'(CELLS));

  // Next state and memory controls
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = sweep_cnt;
    ram_wdata  = {attribute, CH_SPACE};
    ram_raddr  = phys_addr(addr_q, top_base);
    unique case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = BLANK_RESET;
        if (sweep_last_cell) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (op_q)
          OP_PUT: begin
            ram_we     = is_print;
            ram_waddr  = phys_addr(cur_off, top_base);
            ram_wdata  = {attribute, code_q};
            state_next = need_scroll ? S_SCROLL : S_DONE;
          end
          OP_CLEAR: state_next = S_FILL;
          OP_READ:  state_next = read_ok ? S_READ : S_DONE;
          default:  state_next = S_DONE;
        endcase
      end
      S_READ: state_next = S_DONE;
      S_SCROLL: begin
        // old top row becomes the new bottom row
        ram_we    = 1'b1;
        ram_waddr = top_base + sweep_cnt;
        if (sweep_last_row) begin
          state_next = S_DONE;
        end
      end
      S_FILL: begin
        ram_we = 1'b1;
        if (sweep_last_cell) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Attribute register
  always_ff @(posedge clk) begin
    if (rst) begin
      attribute <= ATTR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      attribute <= cfg_data;
    end
  end

  // Command capture
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op_q   <= opcode_t'(opcode);
      code_q <= char_code;
      addr_q <= cell_address;
    end
  end

  // Cursor, ring base and sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col   <= '0;
      cur_row   <= '0;
      cur_off   <= '0;
      top_base  <= '0;
      sweep_cnt <= '0;
    end else begin
      unique case (state)
        S_EXEC: begin
          sweep_cnt <= '0;
          if (op_q == OP_PUT) begin
            cur_col <= col_fin;
            cur_row <= row_fin;
            cur_off <= off_fin;
          end else if (op_q == OP_CLEAR) begin
            cur_col  <= '0;
            cur_row  <= '0;
            cur_off  <= '0;
            top_base <= '0;
          end
        end
        S_SCROLL: begin
          sweep_cnt <= sweep_cnt + ADDR_W'(1);
          if (sweep_last_row) begin
            top_base <= phys_addr(top_base, ADDR_W'(COLUMNS));
          end
        end
        S_INIT, S_FILL: sweep_cnt <= sweep_cnt + ADDR_W'(1);
        default: ;
      endcase
    end
  end

  // Cell data for the result
  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      res_data <= '0;
    end else if (state == S_READ) begin
      res_data <= ram_rdata;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      cursor_column <= cur_col;
      cursor_row    <= cur_row;
      cursor_offset <= cur_off;
      cell_data     <= res_data;
    end
  end

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_screen (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Checks
  a_offset_match: assert property (@(posedge clk) disable iff (rst)
    cur_off == ADDR_W'(cur_row) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col))
    else $error("cursor offset out of step with row and column");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    cur_row < ROW_W'(ROWS) && cur_col < COL_W'(COLUMNS))
    else $error("cursor outside the screen");

  a_write_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ram_waddr < ADDR_W'(CELLS))
    else $error("screen write beyond the store");

  a_base_range: assert property (@(posedge clk) disable iff (rst)
    top_base < ADDR_W'(CELLS))
    else $error("ring base beyond the store");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && out_stall) |=> state == S_DONE)
    else $error("result handed over while output is stalled");

endmodule

// ===== bench/text_console_character_writer_tb.sv =====
// Self-checking bench for the text console character writer: command beats with
// random idling, attribute writes between phases, results checked against a screen model.
// Depends on tcw_pkg and the text_console_character_writer RTL.
module text_console_character_writer_tb;
  import tcw_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 9;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;
  localparam int HOLD_CYCLES   = 300;
  localparam int WATCHDOG_MAX  = 10000;
  localparam int PHASE_ITEMS   = 90;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [ADDR_W-1:0] offset;
    logic [CELL_W-1:0] cell_val;
  } console_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [OP_W-1:0]    opcode = '0;
  logic [CHAR_W-1:0]  char_code = '0;
  logic [ADDR_W-1:0]  cell_address = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [COL_W-1:0]   cursor_column;
  logic [ROW_W-1:0]   cursor_row;
  logic [ADDR_W-1:0]  cursor_offset;
  logic [CELL_W-1:0]  cell_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [ATTR_W-1:0]  cfg_data = '0;

  // Screen model and expected result beats
  logic [CELL_W-1:0]  pred_screen [0:CELLS-1];
  int unsigned        pred_col;
  int unsigned        pred_row;
  logic [ATTR_W-1:0]  pred_attr;
  console_result_t    pending_results [$];

  int errors = 0;
  bit idle_en = 1'b1;
  int hold_seq = 0;

  text_console_character_writer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .char_code(char_code), .cell_address(cell_address),
    .out_valid(out_valid), .out_stall(out_stall),
    .cursor_column(cursor_column), .cursor_row(cursor_row),
    .cursor_offset(cursor_offset), .cell_data(cell_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Blank cells take the attribute in force at the time of filling
  function automatic void blank_cells(int unsigned from, int unsigned count);
    int unsigned i;
    for (i = 0; i < count && from + i < CELLS; i++) begin
      pred_screen[from + i] = {pred_attr, CH_SPACE};
    end
  endfunction

  // Apply one command to the screen model and return its result beat
  function automatic console_result_t console_step(opcode_t op, logic [CHAR_W-1:0] ch,
                                                   logic [ADDR_W-1:0] addr);
    console_result_t r;
    int unsigned col;
    int unsigned row;
    int unsigned i;
    r.cell_val = '0;
    col = pred_col;
    row = pred_row;
    case (op)
      OP_PUT: begin
        if (ch == CH_BS) begin
          if (col != 0) col--;
        end else if (ch == CH_TAB) begin
          col = (col + TAB_WIDTH) & ~(TAB_WIDTH - 1);
        end else if (ch == CH_CR) begin
          col = 0;
        end else if (ch == CH_LF) begin
          col = 0;
          row++;
        end else if (ch >= CH_SPACE) begin
          pred_screen[row * COLUMNS + col] = {pred_attr, ch};
          col++;
        end
        if (col >= COLUMNS) begin
          col = 0;
          row++;
        end
        // Scroll up one row, bottom row becomes blank
        if (row >= ROWS) begin
          for (i = 0; i < CELLS - COLUMNS; i++) begin
            pred_screen[i] = pred_screen[i + COLUMNS];
          end
          blank_cells(CELLS - COLUMNS, COLUMNS);
          row = ROWS - 1;
        end
      end
      OP_CLEAR: begin
        blank_cells(0, CELLS);
        col = 0;
        row = 0;
      end
      OP_READ: begin
        if (addr < CELLS) r.cell_val = pred_screen[addr];
      end
      default: ;
    endcase
    pred_col = col;
    pred_row = row;
    r.col    = COL_W'(col);
    r.row    = ROW_W'(row);
    r.offset = ADDR_W'(row * COLUMNS + col);
    return r;
  endfunction

  // Offer one command beat; valid stays high afterwards unless a gap follows
  task automatic send_command(opcode_t op, logic [CHAR_W-1:0] ch, logic [ADDR_W-1:0] addr);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    char_code    <= ch;
    cell_address <= addr;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(console_step(op, ch, addr));
  endtask

  task automatic put_char(logic [CHAR_W-1:0] ch);
    send_command(OP_PUT, ch, ADDR_W'($urandom));
  endtask

  task automatic read_cell(logic [ADDR_W-1:0] addr);
    send_command(OP_READ, CHAR_W'($urandom), addr);
  endtask

  // Drop valid and wait until every result beat has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_attribute(logic [ATTR_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    pred_attr = value;
  endtask

  // Lowest and highest printable codes, reads at both ends and past the screen
  task automatic test_put_and_read();
    put_char(CH_SPACE);
    put_char(8'hFF);
    read_cell(ADDR_W'(0));
    read_cell(ADDR_W'(1));
    read_cell(ADDR_W'(CELLS - 1));
    read_cell(ADDR_W'(CELLS));
    read_cell('1);
  endtask

  // Cursor moves and control codes that must be ignored
  task automatic test_control_codes();
    put_char(CH_BS);
    put_char(CH_BS);
    put_char(CH_BS);
    put_char(CH_TAB);
    put_char(CH_CR);
    put_char(CH_LF);
    put_char(8'h00);
    put_char(8'h07);
    put_char(8'h1F);
    send_command(OP_NONE, 8'hFF, '1);
  endtask

  task automatic test_clear();
    send_command(OP_CLEAR, CHAR_W'($urandom), ADDR_W'($urandom));
    read_cell(ADDR_W'(0));
  endtask

  // Wrap by tab and by text at the last column, then scroll several times
  task automatic test_wrap_and_scroll();
    int i;
    for (i = 0; i < COLUMNS / TAB_WIDTH; i++) put_char(CH_TAB);
    for (i = 0; i < COLUMNS / TAB_WIDTH - 1; i++) put_char(CH_TAB);
    for (i = 0; i < TAB_WIDTH; i++) put_char(CHAR_W'(8'h41 + i));
    for (i = 0; i < ROWS + 5; i++) begin
      put_char(CHAR_W'(8'h61 + i % 26));
      put_char(CH_LF);
    end
    read_cell(ADDR_W'(0));
    read_cell(ADDR_W'((ROWS - 2) * COLUMNS));
    read_cell(ADDR_W'((ROWS - 1) * COLUMNS));
  endtask

  // Mostly text and line feeds with reads near the cursor, some noise
  task automatic send_random_command();
    int sel;
    int unsigned row;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      put_char(CHAR_W'($urandom_range(CH_SPACE, 255)));
    end else if (sel < 65) begin
      put_char(CH_LF);
    end else if (sel < 70) begin
      case ($urandom_range(0, 2))
        0: put_char(CH_CR);
        1: put_char(CH_BS);
        default: put_char(CH_TAB);
      endcase
    end else if (sel < 74) begin
      put_char(CHAR_W'($urandom_range(0, CH_SPACE - 1)));
    end else if (sel < 94) begin
      row = (pred_row != 0 && $urandom_range(0, 1) == 0) ? pred_row - 1 : pred_row;
      read_cell(ADDR_W'(row * COLUMNS + $urandom_range(0, COLUMNS - 1)));
    end else if (sel < 97) begin
      read_cell(ADDR_W'($urandom_range(0, 2047)));
    end else if (sel < 99) begin
      send_command(OP_NONE, CHAR_W'($urandom), ADDR_W'($urandom));
    end else begin
      send_command(OP_CLEAR, CHAR_W'($urandom), ADDR_W'($urandom));
    end
  endtask

  // Phases under several attributes, the extremes among them
  task automatic test_random_phases();
    logic [ATTR_W-1:0] attrs [6];
    int p;
    int i;
    attrs = '{8'h1E, 8'h00, 8'hFF, ATTR_W'($urandom), 8'h70, ATTR_W'($urandom)};
    for (p = 0; p < 6; p++) begin
      write_attribute(attrs[p]);
      idle_en = (p != 3);
      if (p == 2) send_command(OP_CLEAR, CHAR_W'($urandom), ADDR_W'($urandom));
      for (i = 0; i < PHASE_ITEMS; i++) send_random_command();
    end
    idle_en = 1'b1;
  endtask

  // Receiver holds off while the sender keeps offering short commands
  task automatic test_result_backpressure();
    int i;
    drain_results();
    idle_en = 1'b0;
    hold_seq++;
    for (i = 0; i < 20; i++) begin
      if (i % 3 == 2) read_cell(ADDR_W'($urandom_range(0, CELLS - 1)));
      else put_char(CHAR_W'($urandom_range(CH_SPACE, 255)));
    end
    idle_en = 1'b1;
  endtask

  // Last stretch runs without any idling
  task automatic test_full_rate();
    int i;
    write_attribute(ATTR_W'($urandom));
    idle_en = 1'b0;
    for (i = 0; i < 80; i++) send_random_command();
  endtask

  // Result channel stall: random bursts plus the long hold-off on request
  always @(posedge clk) begin : result_stall
    static int hold_seen = 0;
    static int hold_left = 0;
    static int burst_left = 0;
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (burst_left != 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      burst_left = $urandom_range(1, 14) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin : result_check
    console_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no command outstanding");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (cursor_column !== want.col) begin
          $error("cursor_column: expected %0d, got %0d", want.col, cursor_column);
          errors++;
        end
        if (cursor_row !== want.row) begin
          $error("cursor_row: expected %0d, got %0d", want.row, cursor_row);
          errors++;
        end
        if (cursor_offset !== want.offset) begin
          $error("cursor_offset: expected %0d, got %0d", want.offset, cursor_offset);
          errors++;
        end
        if (cell_data !== want.cell_val) begin
          $error("cell_data: expected %h, got %h", want.cell_val, cell_data);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long without any beat on any channel
  always @(posedge clk) begin : watchdog
    static int quiet_cycles = 0;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_MAX) begin
        $error("timeout: no beat for %0d cycles", WATCHDOG_MAX);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int i;
    for (i = 0; i < CELLS; i++) pred_screen[i] = BLANK_RESET;
    pred_col  = 0;
    pred_row  = 0;
    pred_attr = ATTR_RESET;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_put_and_read();
    test_control_codes();
    test_clear();
    test_wrap_and_scroll();
    test_random_phases();
    test_result_backpressure();
    test_full_rate();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
